// ===== design/twa_pkg.sv =====
// ----------------------------------------------------------------------------
// twa_pkg
// Shared types and constants of the timed window averager.
// ----------------------------------------------------------------------------
package twa_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SUM_WIDTH        = 32;
  localparam int COUNT_WIDTH      = 16;
  localparam int TIME_WIDTH       = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [TIME_WIDTH-1:0]  MIN_WINDOW_MS    = 16'd100;
  localparam logic [TIME_WIDTH-1:0]  WINDOW_RESET_MS  = 16'd1000;
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET      = 16'd1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX        = 16'hFFFF;

  typedef enum logic [1:0] {
    SRC_PASS = 2'd0,
    SRC_HOLD = 2'd1,
    SRC_AVG  = 2'd2
  } src_t;

  typedef enum logic [0:0] {
    REG_NORMAL_WINDOW  = 1'b0,
    REG_THERMAL_WINDOW = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                  wen;
    cfg_reg_t              index;
    logic [TIME_WIDTH-1:0] data;
  } cfg_wr_t;

  // value: sign-extended sample for SRC_PASS, window sum for SRC_AVG
  typedef struct packed {
    src_t                        kind;
    logic signed [SUM_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0]      count;
  } job_t;

endpackage

// ===== design/twa_front.sv =====
// ----------------------------------------------------------------------------
// twa_front
// Takes samples, picks the window, keeps sum, count and window timing, and
// issues one job per sample to the queue.
// ----------------------------------------------------------------------------
module twa_front #(
  parameter int SAMPLE_WIDTH = twa_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  twa_pkg::cfg_wr_t                      cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample,
  input  logic [twa_pkg::TIME_WIDTH-1:0]        now_ms,
  input  logic                                  thermal_active,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output twa_pkg::job_t                         push_job
);

  logic [twa_pkg::TIME_WIDTH-1:0]         normal_win_r, thermal_win_r;
  logic signed [twa_pkg::SUM_WIDTH-1:0]   sum_r, sum_nxt;
  logic [twa_pkg::COUNT_WIDTH-1:0]        count_r, count_nxt;
  logic [twa_pkg::TIME_WIDTH-1:0]         elapsed_r, elapsed_nxt;
  logic [twa_pkg::TIME_WIDTH-1:0]         start_r, start_nxt;

  logic [twa_pkg::TIME_WIDTH-1:0]         window;
  logic signed [twa_pkg::SUM_WIDTH-1:0]   sample_ext;
  logic signed [twa_pkg::SUM_WIDTH:0]     sum_wide;
  logic signed [twa_pkg::SUM_WIDTH-1:0]   sum_sat;
  logic                                   accept;

  assign accept     = in_valid && push_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  assign window     = thermal_active ? thermal_win_r : normal_win_r;
  assign sample_ext = twa_pkg::SUM_WIDTH'(sample);
  assign sum_wide   = (twa_pkg::SUM_WIDTH+1)'(sum_r) + (twa_pkg::SUM_WIDTH+1)'(sample_ext);

  always_comb begin
    if (sum_wide[twa_pkg::SUM_WIDTH] != sum_wide[twa_pkg::SUM_WIDTH-1]) begin
      sum_sat = sum_wide[twa_pkg::SUM_WIDTH] ?
                {1'b1, {(twa_pkg::SUM_WIDTH-1){1'b0}}} :
                {1'b0, {(twa_pkg::SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[twa_pkg::SUM_WIDTH-1:0];
    end
  end

  always_comb begin
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    start_nxt   = start_r;
    push_job.kind  = twa_pkg::SRC_PASS;
    push_job.value = sample_ext;
    push_job.count = count_r;
    if (window < twa_pkg::MIN_WINDOW_MS) begin
      push_job.kind = twa_pkg::SRC_PASS;
    end else if (elapsed_r < window) begin
      push_job.kind = twa_pkg::SRC_HOLD;
      sum_nxt       = sum_sat;
      if (count_r != twa_pkg::COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
      elapsed_nxt   = now_ms - start_r;
    end else begin
      push_job.kind  = twa_pkg::SRC_AVG;
      push_job.value = sum_r;
      sum_nxt        = '0;
      count_nxt      = '0;
      elapsed_nxt    = '0;
      start_nxt      = now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_win_r  <= twa_pkg::WINDOW_RESET_MS;
      thermal_win_r <= twa_pkg::WINDOW_RESET_MS;
      sum_r         <= '0;
      count_r       <= twa_pkg::COUNT_RESET;
      elapsed_r     <= '0;
      start_r       <= '0;
    end else begin
      if (cfg.wen) begin
        case (cfg.index)
          twa_pkg::REG_NORMAL_WINDOW:  normal_win_r  <= cfg.data;
          twa_pkg::REG_THERMAL_WINDOW: thermal_win_r <= cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        sum_r     <= sum_nxt;
        count_r   <= count_nxt;
        elapsed_r <= elapsed_nxt;
        start_r   <= start_nxt;
      end
    end
  end

endmodule

// ===== design/twa_queue.sv =====
// ----------------------------------------------------------------------------
// twa_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module twa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  twa_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output twa_pkg::job_t pop_job
);

  localparam int DEPTH = twa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  twa_pkg::job_t    entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             push, pop;

  assign push_ready = (fill_r != CNT_W'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/twa_back.sv =====
// ----------------------------------------------------------------------------
// twa_back
// Carries out queued jobs: passthrough, hold, or a bit-serial divide of the
// window sum by the count, then drives the output register.
// ----------------------------------------------------------------------------
module twa_back #(
  parameter int SAMPLE_WIDTH = twa_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  twa_pkg::job_t                   pop_job,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]  out_average,
  output twa_pkg::src_t                   out_source
);

  localparam int SW = twa_pkg::SUM_WIDTH;
  localparam int CW = twa_pkg::COUNT_WIDTH;
  localparam int IW = $clog2(SW);
  localparam logic [SW:0] POS_MAX = (SW+1)'((64'd1 << (SAMPLE_WIDTH-1)) - 64'd1);
  localparam logic [SW:0] NEG_MAG = (SW+1)'(64'd1 << (SAMPLE_WIDTH-1));

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } back_state_t;

  back_state_t                   state_r, state_nxt;
  logic [SW-1:0]                 quo_r, quo_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic [CW-1:0]                 div_r, div_nxt;
  logic                          neg_r, neg_nxt;
  logic [IW-1:0]                 iter_r, iter_nxt;
  logic signed [SAMPLE_WIDTH-1:0] last_r, last_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] avg_r, avg_nxt;
  twa_pkg::src_t                 src_r, src_nxt;

  logic                          out_free;
  logic [CW:0]                   rem_sh, rem_diff;
  logic [SW-1:0]                 sum_mag;
  logic [SW:0]                   q_ext, res_ext;

  assign out_free    = !out_valid_r || out_ready;
  assign pop_ready   = (state_r == ST_IDLE) && out_free;
  assign out_valid   = out_valid_r;
  assign out_average = avg_r;
  assign out_source  = src_r;

  assign rem_sh   = {rem_r, quo_r[SW-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign sum_mag  = pop_job.value[SW-1] ? SW'(~pop_job.value + 1'b1) : pop_job.value;
  assign q_ext    = {1'b0, quo_r};

  always_comb begin
    if (neg_r) begin
      res_ext = (q_ext > NEG_MAG) ? (~NEG_MAG + 1'b1) : (~q_ext + 1'b1);
    end else begin
      res_ext = (q_ext > POS_MAX) ? POS_MAX : q_ext;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    neg_nxt       = neg_r;
    iter_nxt      = iter_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    avg_nxt       = avg_r;
    src_nxt       = src_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid && out_free) begin
          case (pop_job.kind)
            twa_pkg::SRC_PASS: begin
              out_valid_nxt = 1'b1;
              avg_nxt       = pop_job.value[SAMPLE_WIDTH-1:0];
              src_nxt       = twa_pkg::SRC_PASS;
              last_nxt      = pop_job.value[SAMPLE_WIDTH-1:0];
            end
            twa_pkg::SRC_HOLD: begin
              out_valid_nxt = 1'b1;
              avg_nxt       = last_r;
              src_nxt       = twa_pkg::SRC_HOLD;
            end
            default: begin
              if (pop_job.count == '0) begin
                out_valid_nxt = 1'b1;
                avg_nxt       = '0;
                src_nxt       = twa_pkg::SRC_AVG;
                last_nxt      = '0;
              end else begin
                quo_nxt   = sum_mag;
                rem_nxt   = '0;
                div_nxt   = pop_job.count;
                neg_nxt   = pop_job.value[SW-1];
                iter_nxt  = IW'(SW-1);
                state_nxt = ST_DIV;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, div_r}) begin
          rem_nxt = rem_diff[CW-1:0];
          quo_nxt = {quo_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CW-1:0];
          quo_nxt = {quo_r[SW-2:0], 1'b0};
        end
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          avg_nxt       = res_ext[SAMPLE_WIDTH-1:0];
          src_nxt       = twa_pkg::SRC_AVG;
          last_nxt      = res_ext[SAMPLE_WIDTH-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    neg_r  <= neg_nxt;
    iter_r <= iter_nxt;
    avg_r  <= avg_nxt;
    src_r  <= src_nxt;
  end

  a_div_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIV || state_r == ST_FIN))
    else $error("divider left its loop early");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && iter_r == '0) |=> (state_r == ST_FIN))
    else $error("divider ran past its last step");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_FIN) |-> (rem_r < div_r))
    else $error("partial remainder not below divisor");

endmodule

// ===== design/timed_window_averager.sv =====
// ----------------------------------------------------------------------------
// timed_window_averager
// Time-window block averager for timestamped climb-rate samples.
//
// Input stream: in_tdata carries sample and now_ms, in_tuser the thermal
// flag; one transfer per sample. Output stream: one transfer per sample,
// out_tdata the average, out_tuser the source code.
// Config: cfg_wen writes cfg_wdata to the register at cfg_index in the
// same cycle (0 normal window, 1 thermal window); write only while idle.
// A front stage takes a sample and queues a job (2 deep); the back stage
// turns a passthrough or hold job straight into its output register, and a
// window-end job through a load, 32 steps of a 1-bit-per-cycle divider and
// a finish step that waits for a free output. A passthrough or hold result
// passes the queue entry and then the output register. While it divides,
// the back stage takes no new job, so samples wait in the queue.
// A stalled output holds its register; the queue keeps taking samples until
// it is full, then in_tready drops. Reset restores window lengths of 1000 ms,
// a count of 1, zero sum, elapsed time, start time and last output.
// ----------------------------------------------------------------------------
module timed_window_averager #(
  parameter int SAMPLE_WIDTH = twa_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wen,
  input  logic [0:0]                            cfg_index,
  input  logic [twa_pkg::TIME_WIDTH-1:0]        cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // sample, now_ms
  input  logic [((SAMPLE_WIDTH+twa_pkg::TIME_WIDTH+7)/8)*8-1:0] in_tdata,
  // thermal_active
  input  logic [0:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // average
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata,
  // source
  output logic [1:0]                            out_tuser
);

  localparam int OUT_DATA_W = ((SAMPLE_WIDTH+7)/8)*8;

  twa_pkg::cfg_wr_t               cfg;
  twa_pkg::job_t                  push_job, pop_job;
  logic                           push_valid, push_ready;
  logic                           pop_valid, pop_ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [SAMPLE_WIDTH-1:0] average;
  twa_pkg::src_t                  source;

  assign cfg.wen   = cfg_wen;
  assign cfg.index = twa_pkg::cfg_reg_t'(cfg_index);
  assign cfg.data  = cfg_wdata;
  assign sample    = in_tdata[SAMPLE_WIDTH-1:0];

  twa_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .sample         (sample),
    .now_ms         (in_tdata[SAMPLE_WIDTH +: twa_pkg::TIME_WIDTH]),
    .thermal_active (in_tuser[0]),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_job       (push_job)
  );

  twa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  twa_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_job     (pop_job),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_average (average),
    .out_source  (source)
  );

  assign out_tdata = OUT_DATA_W'($unsigned(average));
  assign out_tuser = source;

endmodule
